### hdl/wsso_pkg.sv
// Shared types and constants for the saw/square wavetable oscillator.
`timescale 1ns / 1ps

package wsso_pkg;

  // Mix weights in Q0.15: 0.5*0.7 and 0.5*0.3
  localparam logic signed [15:0] MIX_SAW_Q15 = 16'sd11469;
  localparam logic signed [15:0] MIX_SQR_Q15 = 16'sd4915;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // One sample request: phase at which to evaluate the waveform.
  typedef struct packed {
    logic        valid;
    logic [31:0] phase;
  } wsso_req_t;

endpackage

### hdl/wavetable_saw_square_oscillator_top.sv
// Top level of the saw/square wavetable oscillator.
`timescale 1ns / 1ps

// Each tick request with tick=1 yields one signed Q1.15 sample, 0.35*saw + 0.15*square,
// both waveforms linearly interpolated at the current phase, after which the phase
// advances by phase_increment (mod 2^32); tick=0 is taken and yields nothing.
// A new request can be taken every cycle unless the queue is full; a taken request
// goes through the 4-deep request queue, which lets the front keep taking ticks
// while the output is stalled. The phase add in the front end is a registered
// loop; the datapath behind it is a four-register pipeline with two 17x17
// multipliers and two constant multipliers. Write phase_increment only while idle.
module wavetable_saw_square_oscillator_top
  import wsso_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  output logic               tick_stall,
  input  logic               tick,
  output logic               sample_valid,
  input  logic               sample_stall,
  output logic signed [15:0] sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        phase_increment
);

  wsso_req_t push;
  wsso_req_t head;
  logic      q_full;
  logic      pop;

  wsso_front u_front (
    .clk             (clk),
    .rst             (rst),
    .tick_valid      (tick_valid),
    .tick_stall      (tick_stall),
    .tick            (tick),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .phase_increment (phase_increment),
    .q_full          (q_full),
    .push            (push)
  );

  wsso_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  wsso_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample)
  );

endmodule

### hdl/wsso_front.sv
// Front end: takes tick requests, owns the phase accumulator, queues phases.
`timescale 1ns / 1ps

module wsso_front
  import wsso_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_stall,
  input  logic        tick,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] phase_increment,
  input  logic        q_full,
  output wsso_req_t   push
);

  logic [31:0] phase_acc;
  logic [31:0] phase_inc;
  logic        accept;

  assign tick_stall = q_full;
  assign cfg_ready  = 1'b1;
  assign accept     = tick_valid && !tick_stall;

  // tick of 0 is swallowed here: no result, phase holds
  assign push.valid = accept && tick;
  assign push.phase = phase_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      phase_inc <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        phase_inc <= phase_increment;
      end
      if (push.valid) begin
        phase_acc <= phase_acc + phase_inc;
      end
    end
  end

  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    (accept && tick) |=> (phase_acc == $past(phase_acc + phase_inc)))
    else $error("phase did not advance by the increment");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    (!push.valid) |=> $stable(phase_acc))
    else $error("phase moved without a sample request");

endmodule

### hdl/wsso_queue.sv
// Short FIFO of pending sample phases between front end and datapath.
`timescale 1ns / 1ps

module wsso_queue
  import wsso_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  wsso_req_t push,
  output logic      full,
  output wsso_req_t head,
  input  logic      pop
);

  logic [31:0]          mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_pop;

  assign full       = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.phase = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && full))
    else $error("request pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= (QPTR_BITS+1)'(QUEUE_DEPTH)))
    else $error("queue count out of range");

endmodule

### hdl/wsso_back.sv
// Datapath: table entry generation, two linear interpolations, mix, output register.
`timescale 1ns / 1ps

module wsso_back
  import wsso_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  wsso_req_t          head,
  output logic               pop,
  output logic               sample_valid,
  input  logic               sample_stall,
  output logic signed [15:0] sample
);

  localparam int unsigned RAW_BITS = $clog2(TABLE_SIZE);
  localparam int unsigned IB = (RAW_BITS < 2) ? 2 : ((RAW_BITS > 16) ? 16 : RAW_BITS);

  logic en;
  logic v1, v2, v3;

  // stage 1: entries and differences
  logic [IB-1:0]        i0, i1;
  logic [15:0]          frac;
  logic [15:0]          su0, su1;
  logic signed [15:0]   saw0_c, saw1_c, sq0_c, sq1_c;
  logic signed [15:0]   saw0, sq0;
  logic signed [16:0]   saw_d, sq_d;
  logic [15:0]          f1;

  // stage 2: interpolated values
  logic signed [33:0]   saw_p, sq_p;
  logic signed [17:0]   saw_s, sq_s;
  logic signed [15:0]   saw_l, sq_l;

  // stage 3: weighted sum
  logic signed [31:0]   mix_sum;
  logic signed [31:0]   mix_c;

  // output
  logic signed [16:0]   mix_sh;
  logic signed [15:0]   mix_sat;

  assign en  = !(sample_valid && sample_stall);
  assign pop = en;

  assign i0   = head.phase[31 -: IB];
  assign i1   = i0 + 1'b1;
  assign frac = head.phase[31-IB -: 16];

  // saw entry is (i << (16-b)) - 32768: flip the top bit of the shifted index
  assign su0    = 16'(i0) << (16 - IB);
  assign su1    = 16'(i1) << (16 - IB);
  assign saw0_c = $signed(su0 ^ 16'h8000);
  assign saw1_c = $signed(su1 ^ 16'h8000);
  assign sq0_c  = i0[IB-1] ? -16'sd32768 : 16'sd32767;
  assign sq1_c  = i1[IB-1] ? -16'sd32768 : 16'sd32767;

  always_ff @(posedge clk) begin
    if (en) begin
      saw0  <= saw0_c;
      sq0   <= sq0_c;
      saw_d <= 17'(saw1_c) - 17'(saw0_c);
      sq_d  <= 17'(sq1_c) - 17'(sq0_c);
      f1    <= frac;
    end
  end

  assign saw_p = $signed({1'b0, f1}) * saw_d;
  assign sq_p  = $signed({1'b0, f1}) * sq_d;
  assign saw_s = 18'(saw0) + 18'(saw_p >>> 16);
  assign sq_s  = 18'(sq0) + 18'(sq_p >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      saw_l <= saw_s[15:0];
      sq_l  <= sq_s[15:0];
    end
  end

  assign mix_c = 32'(saw_l) * 32'(MIX_SAW_Q15) + 32'(sq_l) * 32'(MIX_SQR_Q15);

  always_ff @(posedge clk) begin
    if (en) begin
      mix_sum <= mix_c;
    end
  end

  assign mix_sh  = 17'(mix_sum >>> 15);
  assign mix_sat = (mix_sh > 17'sd32767)  ? 16'sd32767 :
                   (mix_sh < -17'sd32768) ? -16'sd32768 : mix_sh[15:0];

  always_ff @(posedge clk) begin
    if (en) begin
      sample <= mix_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      sample_valid <= 1'b0;
    end else if (en) begin
      v1           <= head.valid;
      v2           <= v1;
      v3           <= v2;
      sample_valid <= v3;
    end
  end

endmodule
